[sv/lirs_pkg.sv]
// Shared constants, types and codes of the linear interpolation resampler.
package lirs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = 44;
  localparam int STEP_W      = 20;
  localparam int SRC_W       = 25;
  localparam int OCNT_W      = 28;
  localparam int MAX_RESULTS = 10;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int PINT_W      = POS_W - FRAC_BITS;
  localparam int CMP_W       = ((PINT_W > SRC_W) ? PINT_W : SRC_W) + 1;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;

  localparam int APB_DW      = 32;
  localparam int ADDR_W      = 4;
  localparam int REG_IDX_W   = 2;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_STEP   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OCNT   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BYPASS = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_BITS);
  localparam logic [SRC_W-1:0]  SRC_RESET  = SRC_W'(1);
  localparam logic [OCNT_W-1:0] OCNT_RESET = OCNT_W'(1);

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [SRC_W-1:0]  source_count;
    logic [OCNT_W-1:0] output_count;
    logic              bypass;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_LERP,
    KIND_PREV,
    KIND_CUR,
    KIND_ZERO
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT,
    ST_BYPASS
  } state_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic emit;
    logic commit;
    logic byp_emit;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic out_free;
    logic bypass;
  } stat_t;

endpackage

[sv/lirs_regs.sv]
// APB configuration registers of the resampler.
module lirs_regs
  import lirs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step         <= STEP_RESET;
      cfg.source_count <= SRC_RESET;
      cfg.output_count <= OCNT_RESET;
      cfg.bypass       <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_STEP:   cfg.step         <= pwdata[STEP_W-1:0];
        REG_SRC:    cfg.source_count <= pwdata[SRC_W-1:0];
        REG_OCNT:   cfg.output_count <= pwdata[OCNT_W-1:0];
        REG_BYPASS: cfg.bypass       <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STEP:   prdata = APB_DW'(cfg.step);
      REG_SRC:    prdata = APB_DW'(cfg.source_count);
      REG_OCNT:   prdata = APB_DW'(cfg.output_count);
      REG_BYPASS: prdata = APB_DW'(cfg.bypass);
      default:    prdata = '0;
    endcase
  end

endmodule

[sv/lirs_ctrl.sv]
// Sequencing state machine of the resampler.
module lirs_ctrl
  import lirs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = stat.bypass ? ST_BYPASS : ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = stat.go ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = ST_CALC;
        end
      end
      ST_BYPASS: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        cmd.commit = ~stat.go;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      ST_BYPASS: begin
        cmd.byp_emit = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

[sv/lirs_dpath.sv]
// Datapath of the resampler: position, counters, interpolation and output register.
module lirs_dpath
  import lirs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [SAMPLE_BITS-1:0] s_tdata,
  output logic [SAMPLE_BITS-1:0] m_tdata,
  output logic                   m_tvalid,
  output logic                   m_tlast,
  input  logic                   m_tready
);

  logic signed [SAMPLE_BITS-1:0] prev_sample;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic [POS_W-1:0]              position;
  logic [SRC_W-1:0]              inputs_seen;
  logic [OCNT_W-1:0]             outputs_sent;
  logic [RCNT_W-1:0]             res_cnt;
  logic signed [PROD_W-1:0]      prod;
  kind_t                         kind;

  logic [CMP_W-1:0]              pc, nc, sc;
  logic                          after, final_in, ok;
  kind_t                         kind_c;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W-1:0]      prod_c;
  logic [SAMPLE_BITS-1:0]        value;
  logic                          byp_last;

  // Decode where the pending output sits relative to the sample pair
  assign pc       = CMP_W'(position[POS_W-1:FRAC_BITS]);
  assign nc       = CMP_W'(inputs_seen);
  assign sc       = CMP_W'(cfg.source_count);
  assign after    = (nc >= sc);
  assign final_in = ~after & ((nc + CMP_W'(1)) == sc);

  always_comb begin
    ok     = 1'b1;
    kind_c = KIND_ZERO;
    if (after) begin
      kind_c = (pc < sc) ? KIND_PREV : KIND_ZERO;
    end else if (pc < nc) begin
      kind_c = KIND_LERP;
    end else if (final_in && (pc == nc)) begin
      kind_c = KIND_CUR;
    end else if (final_in) begin
      kind_c = KIND_ZERO;
    end else begin
      ok = 1'b0;
    end
  end

  assign stat.go = ok & (res_cnt < RCNT_W'(MAX_RESULTS)) & (outputs_sent < cfg.output_count);
  assign stat.out_free = ~m_tvalid | m_tready;
  assign stat.bypass   = cfg.bypass;

  assign diff   = DIFF_W'(cur_sample) - DIFF_W'(prev_sample);
  assign prod_c = PROD_W'(diff) * $signed({1'b0, position[FRAC_BITS-1:0]});

  // The floor shift keeps only the bits that survive truncation to sample width
  always_comb begin
    case (kind)
      KIND_LERP: value = prev_sample + prod[FRAC_BITS +: SAMPLE_BITS];
      KIND_PREV: value = prev_sample;
      KIND_CUR:  value = cur_sample;
      KIND_ZERO: value = '0;
      default:   value = '0;
    endcase
  end

  assign byp_last = ({1'b0, inputs_seen} + (SRC_W + 1)'(1)) == {1'b0, cfg.source_count};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_sample <= s_tdata;
    end
    if (cmd.calc) begin
      prod <= prod_c;
      kind <= kind_c;
    end
    if (cmd.emit) begin
      m_tdata <= value;
      m_tlast <= ((outputs_sent + OCNT_W'(1)) == cfg.output_count);
    end else if (cmd.byp_emit) begin
      m_tdata <= cur_sample;
      m_tlast <= byp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample  <= '0;
      position     <= '0;
      inputs_seen  <= '0;
      outputs_sent <= '0;
      res_cnt      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        res_cnt <= '0;
      end
      if (cmd.emit) begin
        position     <= position + POS_W'(cfg.step);
        outputs_sent <= outputs_sent + OCNT_W'(1);
        res_cnt      <= res_cnt + RCNT_W'(1);
      end
      if (cmd.commit && !after) begin
        prev_sample <= cur_sample;
        inputs_seen <= inputs_seen + SRC_W'(1);
      end
      if (cmd.byp_emit) begin
        prev_sample <= cur_sample;
        if (inputs_seen != '1) begin
          inputs_seen <= inputs_seen + SRC_W'(1);
        end
      end
      if (cmd.emit || cmd.byp_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[sv/linear_interp_resampler_top.sv]
// Top level of the linear interpolation sample-rate converter.
//
//   channel   direction  transfer when              payload
//   s_*       in         s_tvalid & s_tready        s_tdata[15:0] = sample
//   m_*       out        m_tvalid & m_tready        m_tdata[15:0] = out_sample, m_tlast = last
//   apb       in         psel & penable & pwrite    paddr 4*index, pwdata, prdata
//
// Sequence: after an input transfer, each result takes a step to form the product on
// the single multiplier and a step to load the output register, and a last step
// retires the input (at most ten results per input); bypass instead loads the output
// register with the captured sample. The single multiplier and output register set this order.
// Reset: rst is synchronous, active high; it clears the position, counters and
// previous sample and loads the register reset values.
// Stalls: a result waits in the output register; the next one is formed meanwhile
// and held until the register frees, and input is refused until the item retires.
module linear_interp_resampler_top
  import lirs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Source samples
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
  // Resampled output
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SAMPLE_BITS-1:0] m_tdata,   // [15:0] out_sample
  output logic                   m_tlast,
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Register file: step, source count, output count, bypass
  lirs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequence each input: accept, walk its pending outputs or forward it in bypass, retire
  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold position and counters, interpolate, drive the output register
  lirs_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tlast  (m_tlast),
    .m_tready (m_tready)
  );

endmodule
